@@ rtl/core/ssk_pkg.sv @@
package ssk_pkg;

    localparam int unsigned MAX_IDS_DEF = 16;
    localparam int unsigned NUM_DOMAINS = 3;
    localparam logic [63:0] HASH_MULT   = 64'd1099511628211;
    localparam logic [63:0] HASH_SEED   = 64'd14695981039346656037;
    localparam logic [63:0] SIGN_BIAS   = 64'h8000_0000_0000_0000;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] DOM_ALL     = 2'd0;
    localparam logic [1:0] DOM_ANY     = 2'd1;
    localparam logic [1:0] DOM_EXCLUDE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_HDR,
        S_ID_RD,
        S_ID_WAIT,
        S_BYTE,
        S_MUL_HI,
        S_MUL_SUM,
        S_OUT
    } t_state;

    // Request from the controller to the FNV unit: one 64-bit word to absorb.
    typedef struct packed {
        logic        start;
        logic        init;
        logic [63:0] word;
    } t_hash_req;

    typedef struct packed {
        logic        busy;
        logic [63:0] hash;
    } t_hash_rsp;

endpackage

@@ rtl/core/ssk_fnv.sv @@
// Absorbs one 64-bit word into the FNV-1a hash, one byte at a time:
// xor, then the 64-bit product split into a low and a high 32-bit partial product.
module ssk_fnv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssk_pkg::t_hash_req  i_req,
    output ssk_pkg::t_hash_rsp  o_rsp
);

    logic [1:0]  r_phase;
    logic [2:0]  r_byte;
    logic        r_busy;
    logic [63:0] r_hash;
    logic [63:0] r_word;
    logic [63:0] r_lo;
    logic [31:0] r_hi;
    logic [63:0] w_x;

    assign w_x = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 2'd0;
            r_byte  <= 3'd0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_phase <= 2'd0;
            r_byte  <= 3'd0;
        end else if (r_busy) begin
            unique case (r_phase)
                2'd0: r_phase <= 2'd1;
                2'd1: r_phase <= 2'd2;
                default: begin
                    r_phase <= 2'd0;
                    r_byte  <= r_byte + 3'd1;
                    if (r_byte == 3'd7) begin
                        r_busy <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_word <= i_req.word;
            if (i_req.init) begin
                r_hash <= ssk_pkg::HASH_SEED;
            end
        end else if (r_busy) begin
            unique case (r_phase)
                2'd0: begin
                    r_hash <= r_hash ^ {56'd0, r_word[7:0]};
                    r_word <= r_word >> 8;
                end
                2'd1: begin
                    r_lo <= 64'(w_x[31:0] * ssk_pkg::HASH_MULT[31:0]);
                    r_hi <= 32'(w_x[63:32] * ssk_pkg::HASH_MULT[31:0]
                              + w_x[31:0] * ssk_pkg::HASH_MULT[63:32]);
                end
                default: begin
                    r_hash <= r_lo + {r_hi, 32'd0};
                end
            endcase
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.hash = r_hash;

endmodule

@@ rtl/core/ssk_store.sv @@
// Id memory: one write port, one registered read port.
module ssk_store #(
    parameter int unsigned DEPTH = 48,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/sorted_set_fnv1a_key.sv @@
// Sorted id-set key builder with a 64-bit FNV-1a hash over three id domains.
//
// Input channel (i_valid/o_ready): i_operation, i_domain, i_id. An add beat
// inserts i_id into the domain's ascending list held in a single memory;
// the insertion shifts larger ids up one place at a time, each step reading
// the id below (S_INS_RD) and then comparing and writing (S_INS_CMP), until
// the id lands. An add to domain 3 is ignored, an add to a full domain is
// dropped and sets the overflow flag; neither leaves the idle state.
// A finish beat hashes marker, count and sorted ids of each domain, byte by
// byte through one FNV unit; the key and the flag are registered in S_OUT.
// Output channel (o_valid/i_ready): o_key and o_overflow, one beat per
// finish. The result is held in an output register until taken; the block
// takes the next item only once that result is gone. The counts and the
// flag are cleared when the finish completes.
// Reset clears counts, flag and control; the memory needs no clearing since
// only entries below a domain's count are ever used.
module sorted_set_fnv1a_key #(
    parameter int unsigned MAX_IDS = ssk_pkg::MAX_IDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [1:0]  i_domain,
    input  logic [63:0] i_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_key,
    output logic        o_overflow
);

    localparam int unsigned DEPTH = ssk_pkg::NUM_DOMAINS * MAX_IDS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(MAX_IDS + 1);

    ssk_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_cnt [3];
    logic          r_ovf;
    logic [1:0]    r_dom;
    logic [63:0]   r_id;
    logic [CW-1:0] r_pos;
    logic [1:0]    r_hdr;
    logic [CW-1:0] r_k;
    logic          r_out_v;
    logic [63:0]   r_key;
    logic          r_key_ovf;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [63:0]   w_wdata, w_rdata;
    logic [AW-1:0] w_base;
    logic [CW-1:0] w_pm1;
    logic          w_less;
    logic          w_acc;
    ssk_pkg::t_hash_req w_req;
    ssk_pkg::t_hash_rsp w_rsp;

    assign w_acc  = i_valid && o_ready;
    assign w_base = AW'(r_dom * MAX_IDS);
    assign w_pm1  = r_pos - CW'(1);
    assign w_less = (r_id ^ ssk_pkg::SIGN_BIAS) < (w_rdata ^ ssk_pkg::SIGN_BIAS);

    ssk_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    ssk_fnv u_fnv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssk_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (i_operation == ssk_pkg::OP_FINISH) begin
                        n_state = ssk_pkg::S_HDR;
                    end else if (i_domain != 2'd3
                                 && r_cnt[i_domain] != CW'(MAX_IDS)) begin
                        n_state = ssk_pkg::S_INS_RD;
                    end
                end
            end
            ssk_pkg::S_INS_RD: begin
                n_state = (r_pos == '0) ? ssk_pkg::S_IDLE : ssk_pkg::S_INS_CMP;
            end
            ssk_pkg::S_INS_CMP: begin
                n_state = w_less ? ssk_pkg::S_INS_RD : ssk_pkg::S_IDLE;
            end
            ssk_pkg::S_HDR: begin
                if (!w_rsp.busy && r_hdr[0] == 1'b1 && r_k == '1) begin
                    n_state = ssk_pkg::S_ID_RD;
                end
            end
            ssk_pkg::S_ID_RD: begin
                if (!w_rsp.busy) begin
                    if (r_k == r_cnt[r_dom]) begin
                        n_state = (r_dom == ssk_pkg::DOM_EXCLUDE)
                                  ? ssk_pkg::S_OUT : ssk_pkg::S_HDR;
                    end else begin
                        n_state = ssk_pkg::S_ID_WAIT;
                    end
                end
            end
            ssk_pkg::S_ID_WAIT: n_state = ssk_pkg::S_BYTE;
            ssk_pkg::S_BYTE:    n_state = ssk_pkg::S_ID_RD;
            ssk_pkg::S_OUT:     n_state = ssk_pkg::S_IDLE;
            default:            n_state = ssk_pkg::S_IDLE;
        endcase
    end

    // Header words: r_hdr[0] picks marker (0) or count (1); r_k all ones marks
    // that the word has been handed to the hash unit.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_base + AW'(r_pos);
        w_wdata = r_id;
        w_raddr = w_base + AW'(w_pm1);
        w_req   = '0;
        unique case (r_state)
            ssk_pkg::S_INS_RD: begin
                if (r_pos == '0) begin
                    w_we = 1'b1;
                end
            end
            ssk_pkg::S_INS_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_less ? w_rdata : r_id;
            end
            ssk_pkg::S_HDR: begin
                if (!w_rsp.busy && r_k != '1) begin
                    w_req.start = 1'b1;
                    w_req.init  = (r_dom == ssk_pkg::DOM_ALL) && !r_hdr[0];
                    w_req.word  = r_hdr[0] ? 64'(r_cnt[r_dom]) : 64'(r_dom) + 64'd1;
                end
            end
            // The read data register reloads every cycle, so the id address
            // is held until the word has been handed over.
            ssk_pkg::S_ID_RD, ssk_pkg::S_ID_WAIT: begin
                w_raddr = w_base + AW'(r_k);
            end
            ssk_pkg::S_BYTE: begin
                w_req.start = 1'b1;
                w_req.word  = w_rdata;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == ssk_pkg::S_IDLE) && !r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssk_pkg::S_IDLE;
            r_cnt     <= '{default: '0};
            r_ovf     <= 1'b0;
            r_out_v   <= 1'b0;
            r_hdr     <= '0;
            r_k       <= '0;
            r_dom     <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ssk_pkg::S_IDLE: begin
                    if (w_acc) begin
                        r_id  <= i_id;
                        r_dom <= (i_operation == ssk_pkg::OP_FINISH)
                                 ? ssk_pkg::DOM_ALL : i_domain;
                        r_hdr <= '0;
                        r_k   <= '0;
                        if (i_operation == ssk_pkg::OP_ADD && i_domain != 2'd3) begin
                            if (r_cnt[i_domain] == CW'(MAX_IDS)) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_pos           <= r_cnt[i_domain];
                                r_cnt[i_domain] <= r_cnt[i_domain] + CW'(1);
                            end
                        end
                    end
                end
                ssk_pkg::S_INS_CMP: begin
                    if (w_less) begin
                        r_pos <= w_pm1;
                    end
                end
                ssk_pkg::S_HDR: begin
                    if (!w_rsp.busy) begin
                        if (r_k != '1) begin
                            r_k <= '1;
                        end else if (!r_hdr[0]) begin
                            r_hdr <= 2'd1;
                            r_k   <= '0;
                        end else begin
                            r_k <= '0;
                        end
                    end
                end
                ssk_pkg::S_ID_RD: begin
                    if (!w_rsp.busy && r_k == r_cnt[r_dom]) begin
                        r_dom <= r_dom + 2'd1;
                        r_hdr <= '0;
                        r_k   <= '0;
                    end
                end
                ssk_pkg::S_BYTE: begin
                    r_k <= r_k + CW'(1);
                end
                ssk_pkg::S_OUT: begin
                    r_out_v   <= 1'b1;
                    r_key     <= w_rsp.hash;
                    r_key_ovf <= r_ovf;
                    r_ovf     <= 1'b0;
                    r_cnt     <= '{default: '0};
                end
                default: ;
            endcase
        end
    end

    assign o_valid    = r_out_v;
    assign o_key      = r_key;
    assign o_overflow = r_key_ovf;

endmodule

@@ rtl/core/ssk_checker.sv @@
module ssk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_operation,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_key
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_key))
        else $error("result beat dropped or changed while stalled");

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result waits");

    a_add_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_operation |=> !o_valid)
        else $error("add beat produced a result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

bind sorted_set_fnv1a_key ssk_checker u_ssk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_operation(i_operation),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_key      (o_key)
);

@@ verif/tb_sorted_set_fnv1a_key.sv @@
`timescale 1ns / 100ps

class key_scoreboard;
    bit [63:0] ids [3][$];
    bit        ovf_flag;
    bit [63:0] key_q [$];
    bit        ovf_q [$];
    int        errors;

    function bit [63:0] fnv_word(bit [63:0] h, bit [63:0] v);
        for (int i = 0; i < 8; i++) begin
            h = h ^ {56'd0, v[8*i +: 8]};
            h = h * ssk_pkg::HASH_MULT;
        end
        return h;
    endfunction

    // Notes one accepted input beat and, on a finish, queues the expected key.
    function void note_input(bit op, bit [1:0] dom, bit [63:0] id);
        bit [63:0] h;
        int pos;
        if (op == ssk_pkg::OP_ADD) begin
            if (dom > ssk_pkg::DOM_EXCLUDE) return;
            if (ids[dom].size() >= ssk_pkg::MAX_IDS_DEF) begin
                ovf_flag = 1'b1;
                return;
            end
            pos = ids[dom].size();
            while (pos > 0 && $signed(id) < $signed(ids[dom][pos-1])) pos--;
            ids[dom].insert(pos, id);
        end else begin
            h = ssk_pkg::HASH_SEED;
            for (int d = 0; d < 3; d++) begin
                h = fnv_word(h, 64'(d + 1));
                h = fnv_word(h, 64'(ids[d].size()));
                foreach (ids[d][k]) h = fnv_word(h, ids[d][k]);
                ids[d].delete();
            end
            key_q = {key_q, h};
            ovf_q = {ovf_q, ovf_flag};
            ovf_flag = 1'b0;
        end
    endfunction

    function void check_result(bit [63:0] key, bit ovf);
        bit [63:0] ek;
        bit eo;
        if (key_q.size() == 0) begin
            $error("unexpected result key=%h overflow=%0b", key, ovf);
            errors++;
            return;
        end
        ek = key_q.pop_front();
        eo = ovf_q.pop_front();
        if (ek !== key) begin
            $error("key: expected %h actual %h", ek, key);
            errors++;
        end
        if (eo !== ovf) begin
            $error("overflow: expected %0b actual %0b", eo, ovf);
            errors++;
        end
    endfunction
endclass

module tb_sorted_set_fnv1a_key;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = ssk_pkg::OP_ADD;
    logic [1:0]  i_domain = ssk_pkg::DOM_ALL;
    logic [63:0] i_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_key;
    logic        o_overflow;

    key_scoreboard sb = new();
    bit  stim_done = 1'b0;
    bit  hold_off = 1'b0;
    int  idle_cycles = 0;
    localparam int WATCHDOG = 20000;

    sorted_set_fnv1a_key DUT (.*);

    always #4 i_clk = ~i_clk;

    // Drives one beat, idling first for a random number of cycles. Valid is
    // only dropped when a gap follows, so back-to-back beats keep it high.
    task automatic send_beat(bit op, bit [1:0] dom, bit [63:0] id);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_domain    <= dom;
        i_id        <= id;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(op, dom, id);
    endtask

    function automatic bit [63:0] rand_id();
        case ($urandom_range(0, 5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'($signed($urandom_range(0, 8)) - 4);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_set(int n);
        bit [63:0] last;
        for (int k = 0; k < n; k++) begin
            // Repeat the previous id now and then so that duplicates occur.
            if (k > 0 && $urandom_range(0, 7) == 0) begin
                send_beat(ssk_pkg::OP_ADD, 2'($urandom_range(0, 2)), last);
            end else begin
                last = rand_id();
                send_beat(ssk_pkg::OP_ADD,
                          ($urandom_range(0, 30) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                          last);
            end
        end
        send_beat(ssk_pkg::OP_FINISH, 2'($urandom_range(0, 3)), {$urandom, $urandom});
    endtask

    initial begin
        int sent;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: empty key, extremes, ignored domain, one domain overfilled.
        send_beat(ssk_pkg::OP_FINISH, ssk_pkg::DOM_ALL, '0);
        send_beat(ssk_pkg::OP_ADD, ssk_pkg::DOM_ALL, 64'h7FFF_FFFF_FFFF_FFFF);
        send_beat(ssk_pkg::OP_ADD, ssk_pkg::DOM_ALL, 64'h8000_0000_0000_0000);
        send_beat(ssk_pkg::OP_ADD, ssk_pkg::DOM_ALL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(ssk_pkg::OP_ADD, ssk_pkg::DOM_ANY, 64'd0);
        send_beat(ssk_pkg::OP_ADD, ssk_pkg::DOM_ANY, 64'd0);
        send_beat(ssk_pkg::OP_ADD, ssk_pkg::DOM_EXCLUDE, 64'd1);
        send_beat(ssk_pkg::OP_ADD, 2'd3, 64'd5);
        send_beat(ssk_pkg::OP_FINISH, 2'd3, '1);
        for (int k = 0; k < 18; k++) begin
            send_beat(ssk_pkg::OP_ADD, ssk_pkg::DOM_EXCLUDE, 64'(17 - k));
        end
        send_beat(ssk_pkg::OP_FINISH, ssk_pkg::DOM_ALL, '0);
        sent = 30;
        // Long receiver stall while finishes keep arriving.
        hold_off = 1'b1;
        for (int k = 0; k < 3; k++) send_set(2);
        sent += 9;
        while (sent < 1700) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 55) : $urandom_range(0, 10);
            send_set(n);
            sent += n + 1;
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin
        int gap;
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_key, o_overflow);
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (!(stim_done && sb.key_q.size() == 0)) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.key_q.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG);
        $display("status: fail");
        $finish;
    end
endmodule
